@@ hdl/rpb_pkg.sv @@
// ---------------------------------------------------------------------------
// rpb_pkg: shared definitions for the reverse playback buffer
// Sizes, fixed-point constants, register indexes and the types that pass
// between the channel lanes and the top level.
// ---------------------------------------------------------------------------
package rpb_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int MAX_REV_LEN = 131072;
    localparam int ADDR_W      = $clog2(MAX_REV_LEN);
    localparam int LEN_W       = 18;
    localparam int FADE_W      = 14;
    localparam int RECIP_W     = 17;
    localparam int Q_BITS      = 16;
    localparam int GAIN_W      = Q_BITS + 1;
    localparam int PROD_W      = FADE_W + RECIP_W;
    localparam int SCALE_W     = SAMPLE_BITS + GAIN_W;
    localparam int CNT_W       = $clog2(LEN_W);
    localparam int CFG_W       = LEN_W;
    localparam int CFG_IDX_W   = 3;

    localparam logic [GAIN_W-1:0]  Q16_ONE    = GAIN_W'(1 << Q_BITS);
    localparam logic [SCALE_W-1:0] ROUND_HALF = SCALE_W'(1 << (Q_BITS - 1));

    localparam logic [CFG_IDX_W-1:0] REG_REV_LEN_LEFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REV_LEN_RIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_LEN_LEFT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_LEN_RIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_RECIP_LEFT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_RECIP_RIGHT = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_RAMP,
        ST_SCALE,
        ST_ROUND,
        ST_MOD,
        ST_WB,
        ST_DONE
    } lane_state_t;

    typedef enum logic [1:0] {
        GM_NONE,
        GM_RAMP,
        GM_INV
    } gain_mode_t;

    typedef struct packed {
        logic [LEN_W-1:0]   rev_len;
        logic [FADE_W-1:0]  fade_len;
        logic [RECIP_W-1:0] fade_recip;
    } lane_cfg_t;

    typedef struct packed {
        logic start;
        logic ack;
    } lane_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } lane_sts_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } clr_t;

endpackage

@@ hdl/rpb_lane.sv @@
// ---------------------------------------------------------------------------
// rpb_lane: one channel of the reverse playback buffer
// Holds the channel's ring store and write position, reads the store
// backwards, applies the fade gain and writes the new sample.
// ---------------------------------------------------------------------------
module rpb_lane
    import rpb_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lane_cfg_t                     cfg,
    input  clr_t                          clr,
    input  lane_ctl_t                     ctl,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output lane_sts_t                     sts,
    output logic signed [SAMPLE_BITS-1:0] result
);

    localparam int PW = LEN_W + 2;

    logic signed [SAMPLE_BITS-1:0] mem [MAX_REV_LEN];

    lane_state_t                   state_reg, state_next;
    logic [ADDR_W-1:0]             pos_reg, pos_next;
    logic [LEN_W-1:0]              len_reg;
    logic [ADDR_W-1:0]             play_reg;
    logic signed [SAMPLE_BITS-1:0] in_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic [FADE_W-1:0]             n_reg;
    gain_mode_t                    mode_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic [SCALE_W-1:0]            scaled_reg;
    logic                          neg_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic [LEN_W-1:0]              rem_reg, rem_next;
    logic [LEN_W-1:0]              div_reg;
    logic                          mod_pending_reg;
    logic [CNT_W-1:0]              bit_cnt_reg;

    logic [LEN_W-1:0]              len_clamp;
    logic [LEN_W-1:0]              len_m1;
    logic signed [PW-1:0]          play_diff;
    logic [ADDR_W-1:0]             play_c;
    logic signed [PW-1:0]          p_s, l_s, f_s, m_s, n_s;
    gain_mode_t                    mode_c;
    logic [GAIN_W-1:0]             ramp_c;
    logic [GAIN_W-1:0]             gain_c;
    logic [SAMPLE_BITS-1:0]        rd_u;
    logic [SAMPLE_BITS-1:0]        mag_c;
    logic [SCALE_W-1:0]            rnd_sum;
    logic [SAMPLE_BITS-1:0]        res_mag;
    logic [LEN_W-1:0]              pos_inc;
    logic [LEN_W-1:0]              shifted;
    logic                          mem_we;

    // Store length clamped to 1..MAX_REV_LEN and read position.
    always_comb
    begin
        if (cfg.rev_len == '0)
        begin
            len_clamp = LEN_W'(1);
        end
        else if (cfg.rev_len > LEN_W'(MAX_REV_LEN))
        begin
            len_clamp = LEN_W'(MAX_REV_LEN);
        end
        else
        begin
            len_clamp = cfg.rev_len;
        end
        len_m1    = len_clamp - LEN_W'(1);
        play_diff = signed'({2'b00, len_clamp}) - signed'({{(PW - ADDR_W){1'b0}}, pos_reg});
        if (play_diff[PW-1])
        begin
            play_c = '0;
        end
        else if (play_diff[LEN_W-1:0] == len_clamp)
        begin
            play_c = len_m1[ADDR_W-1:0];
        end
        else
        begin
            play_c = play_diff[ADDR_W-1:0];
        end
    end

    // Fade region decode. The rules around the middle of the store come last
    // and override the start and end ramps.
    always_comb
    begin
        p_s    = signed'({{(PW - ADDR_W){1'b0}}, play_reg});
        l_s    = signed'({2'b00, len_reg});
        f_s    = signed'({{(PW - FADE_W){1'b0}}, cfg.fade_len});
        m_s    = signed'({3'b000, len_reg[LEN_W-1:1]});
        mode_c = GM_NONE;
        n_s    = '0;
        if (p_s < f_s)
        begin
            mode_c = GM_RAMP;
            n_s    = p_s;
        end
        if (p_s > l_s - f_s)
        begin
            mode_c = GM_RAMP;
            n_s    = l_s - p_s;
        end
        if (p_s >= m_s - f_s && p_s <= m_s)
        begin
            mode_c = GM_INV;
            n_s    = p_s - (m_s - f_s);
        end
        if (p_s > m_s && p_s <= m_s + f_s)
        begin
            mode_c = GM_RAMP;
            n_s    = p_s - m_s;
        end
    end

    // Gain and magnitude for the scaling multiply.
    always_comb
    begin
        if (prod_reg > PROD_W'(Q16_ONE))
        begin
            ramp_c = Q16_ONE;
        end
        else
        begin
            ramp_c = prod_reg[GAIN_W-1:0];
        end
        case (mode_reg)
            GM_RAMP: gain_c = ramp_c;
            GM_INV:  gain_c = Q16_ONE - ramp_c;
            default: gain_c = Q16_ONE;
        endcase
        rd_u    = unsigned'(rd_data_reg);
        mag_c   = rd_u[SAMPLE_BITS-1] ? (~rd_u + 1'b1) : rd_u;
        rnd_sum = scaled_reg + ROUND_HALF;
        res_mag = rnd_sum[Q_BITS+SAMPLE_BITS-1:Q_BITS];
    end

    // Write position update. A stale position beyond the store length takes
    // the bit-serial remainder path.
    always_comb
    begin
        pos_inc = {1'b0, pos_reg} + LEN_W'(1);
        shifted = {rem_reg[LEN_W-2:0], div_reg[bit_cnt_reg]};
        rem_next = rem_reg;
        case (state_reg)
            ST_READ:
            begin
                if (pos_inc < len_reg)
                begin
                    rem_next = pos_inc;
                end
                else
                begin
                    rem_next = '0;
                end
            end
            ST_MOD:
            begin
                if (shifted >= len_reg)
                begin
                    rem_next = shifted - len_reg;
                end
                else
                begin
                    rem_next = shifted;
                end
            end
            default: rem_next = rem_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (ctl.start) state_next = ST_READ;
            ST_READ:  state_next = ST_RAMP;
            ST_RAMP:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_ROUND;
            ST_ROUND: state_next = mod_pending_reg ? ST_MOD : ST_WB;
            ST_MOD:   if (bit_cnt_reg == '0) state_next = ST_WB;
            ST_WB:    state_next = ST_DONE;
            ST_DONE:  if (ctl.ack) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        sts.idle = (state_reg == ST_IDLE);
        sts.done = (state_reg == ST_DONE);
        mem_we   = (state_reg == ST_WB);
        pos_next = mem_we ? rem_reg[ADDR_W-1:0] : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    in_reg   <= sample_in;
                    len_reg  <= len_clamp;
                    play_reg <= play_c;
                end
            end
            ST_READ:
            begin
                n_reg           <= n_s[FADE_W-1:0];
                mode_reg        <= mode_c;
                mod_pending_reg <= (pos_inc > len_reg);
                div_reg         <= pos_inc;
                bit_cnt_reg     <= CNT_W'(LEN_W - 1);
            end
            ST_RAMP:
            begin
                prod_reg <= PROD_W'(n_reg) * PROD_W'(cfg.fade_recip);
            end
            ST_SCALE:
            begin
                scaled_reg <= SCALE_W'(mag_c) * SCALE_W'(gain_c);
                neg_reg    <= rd_u[SAMPLE_BITS-1];
            end
            ST_ROUND:
            begin
                if (len_reg == LEN_W'(1))
                begin
                    out_reg <= in_reg;
                end
                else
                begin
                    out_reg <= neg_reg ? signed'(-res_mag) : signed'(res_mag);
                end
            end
            ST_MOD:
            begin
                bit_cnt_reg <= bit_cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // The read of the old sample and the write of the new one never meet
    // in the same cycle, and the clearing pass never overlaps an item.
    always_ff @(posedge clk)
    begin
        if (clr.en)
        begin
            mem[clr.addr] <= '0;
        end
        else if (mem_we)
        begin
            mem[rem_reg[ADDR_W-1:0]] <= in_reg;
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= mem[play_reg];
        end
    end

    assign result = out_reg;

    a_play_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> ({1'b0, play_reg} < len_reg))
        else $error("read position outside the store");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |-> ({1'b0, pos_reg} < len_reg))
        else $error("write position not reduced below the store length");

    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCALE |-> gain_c <= Q16_ONE)
        else $error("fade gain above unity");

endmodule

@@ hdl/reverse_playback_buffer_with_fades_top.sv @@
// ---------------------------------------------------------------------------
// reverse_playback_buffer_with_fades_top: stereo reverse playback buffer
// Two channel lanes with fade gain, a configuration register file, the
// store clearing sweep and the output register that merges both lanes.
// ---------------------------------------------------------------------------
// After reset the block sweeps both sample stores to zero, one entry per
// cycle; during that time in_stall stays high while configuration writes
// are still taken. Each beat then runs through both channel lanes side by
// side: store read, ramp multiply, gain multiply, rounding and store write.
// The pair of results is loaded into the output register once both lanes
// are done and the output register is free, and only then is the next
// input beat taken. When a length has been lowered to or below a channel's
// current write position, that channel reduces the position with a
// bit-serial remainder before the store write. A finished result waits in
// the output register while the next beat is already being processed.
module reverse_playback_buffer_with_fades_top
    import rpb_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data
);

    logic [LEN_W-1:0]              rev_len_left_reg;
    logic [LEN_W-1:0]              rev_len_right_reg;
    logic [FADE_W-1:0]             fade_len_left_reg;
    logic [FADE_W-1:0]             fade_len_right_reg;
    logic [RECIP_W-1:0]            fade_recip_left_reg;
    logic [RECIP_W-1:0]            fade_recip_right_reg;

    logic                          clr_busy_reg;
    logic [ADDR_W-1:0]             clr_addr_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;

    lane_cfg_t                     cfg_left, cfg_right;
    lane_ctl_t                     ctl;
    lane_sts_t                     sts_left, sts_right;
    clr_t                          clr;
    logic signed [SAMPLE_BITS-1:0] res_left, res_right;
    logic                          accept;
    logic                          load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rev_len_left_reg     <= LEN_W'(1);
            rev_len_right_reg    <= LEN_W'(1);
            fade_len_left_reg    <= FADE_W'(1);
            fade_len_right_reg   <= FADE_W'(1);
            fade_recip_left_reg  <= RECIP_W'(Q16_ONE);
            fade_recip_right_reg <= RECIP_W'(Q16_ONE);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REV_LEN_LEFT:     rev_len_left_reg     <= cfg_data[LEN_W-1:0];
                REG_REV_LEN_RIGHT:    rev_len_right_reg    <= cfg_data[LEN_W-1:0];
                REG_FADE_LEN_LEFT:    fade_len_left_reg    <= cfg_data[FADE_W-1:0];
                REG_FADE_LEN_RIGHT:   fade_len_right_reg   <= cfg_data[FADE_W-1:0];
                REG_FADE_RECIP_LEFT:  fade_recip_left_reg  <= cfg_data[RECIP_W-1:0];
                REG_FADE_RECIP_RIGHT: fade_recip_right_reg <= cfg_data[RECIP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Store clearing sweep after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(MAX_REV_LEN - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        cfg_left.rev_len     = rev_len_left_reg;
        cfg_left.fade_len    = fade_len_left_reg;
        cfg_left.fade_recip  = fade_recip_left_reg;
        cfg_right.rev_len    = rev_len_right_reg;
        cfg_right.fade_len   = fade_len_right_reg;
        cfg_right.fade_recip = fade_recip_right_reg;
        clr.en               = clr_busy_reg;
        clr.addr             = clr_addr_reg;
        in_stall             = clr_busy_reg | ~(sts_left.idle & sts_right.idle);
        accept               = in_valid & ~in_stall;
        load                 = sts_left.done & sts_right.done
                               & (~out_valid_reg | ~out_stall);
        ctl.start            = accept;
        ctl.ack              = load;
    end

    rpb_lane u_lane_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_left),
        .clr       (clr),
        .ctl       (ctl),
        .sample_in (left_in),
        .sts       (sts_left),
        .result    (res_left)
    );

    rpb_lane u_lane_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_right),
        .clr       (clr),
        .ctl       (ctl),
        .sample_in (right_in),
        .sts       (sts_right),
        .result    (res_right)
    );

    // Both lanes must finish before the pair goes out as one beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_out_reg  <= res_left;
            right_out_reg <= res_right;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    a_lanes_start_together: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (!sts_left.idle && !sts_right.idle))
        else $error("channel lanes did not start on the same beat");

endmodule

@@ verif/rpb_frame_checker.sv @@
// ---------------------------------------------------------------------------
// rpb_frame_checker: result predictor and scoreboard for the reverse buffer
// Mirrors register writes, predicts both channels of every accepted input
// beat and compares each output beat with the oldest predicted frame.
// ---------------------------------------------------------------------------
module rpb_frame_checker
    import rpb_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic signed [SAMPLE_BITS-1:0] left_out,
    input  logic signed [SAMPLE_BITS-1:0] right_out,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    output int                            mismatch_count,
    output int                            frames_pending,
    output int                            frames_checked
);

    localparam int     LEFT_CH      = 0;
    localparam int     RIGHT_CH     = 1;
    localparam longint GAIN_ONE     = 64'd1 << Q_BITS;
    localparam int     REPORT_LIMIT = 40;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } stereo_frame_t;

    stereo_frame_t expected_frames [$];

    logic signed [SAMPLE_BITS-1:0] sample_store [2][MAX_REV_LEN];
    longint                        write_pos [2];
    logic [LEN_W-1:0]              rev_len [2];
    logic [FADE_W-1:0]             fade_len [2];
    logic [RECIP_W-1:0]            fade_recip [2];

    // Reset is applied once at time zero, so the reset state is set up here.
    initial
    begin
        for (int ch = 0; ch < 2; ch++)
        begin
            for (int a = 0; a < MAX_REV_LEN; a++)
                sample_store[ch][a] = '0;
            write_pos[ch]  = 0;
            rev_len[ch]    = 1;
            fade_len[ch]   = 1;
            fade_recip[ch] = RECIP_W'(GAIN_ONE);
        end
        mismatch_count = 0;
        frames_pending = 0;
        frames_checked = 0;
    end

    function automatic longint ramp_gain(longint span, longint recip);
        longint prod;
        if (span <= 0)
            return 0;
        prod = span * recip;
        return (prod > GAIN_ONE) ? GAIN_ONE : prod;
    endfunction

    // Reads one channel backwards, applies the fade gain, then stores the new
    // sample at the advanced write position.
    function automatic logic signed [SAMPLE_BITS-1:0] reverse_faded_sample(
        int ch, logic signed [SAMPLE_BITS-1:0] smp);
        longint len, fade, recip, play, mid, gain, stored, mag, scaled;
        len   = rev_len[ch];
        fade  = fade_len[ch];
        recip = fade_recip[ch];
        if (len < 1)
            len = 1;
        if (len > MAX_REV_LEN)
            len = MAX_REV_LEN;
        play = len - write_pos[ch];
        if (play < 0)
            play = 0;
        if (play > len - 1)
            play = len - 1;
        gain = GAIN_ONE;
        if (play < fade)
            gain = ramp_gain(play, recip);
        if (play > len - fade)
            gain = ramp_gain(len - play, recip);
        mid = len / 2;
        // The dip around the middle overrides the edge ramps.
        if (play >= mid - fade && play <= mid)
            gain = GAIN_ONE - ramp_gain(play - (mid - fade), recip);
        if (play > mid && play <= mid + fade)
            gain = ramp_gain(play - mid, recip);
        if (len > 1)
        begin
            stored = sample_store[ch][play];
            mag    = (stored < 0) ? -stored : stored;
            mag    = (mag * gain + (GAIN_ONE >> 1)) >>> Q_BITS;
            scaled = (stored < 0) ? -mag : mag;
        end
        else
            scaled = smp;
        write_pos[ch] = (write_pos[ch] + 1) % len;
        sample_store[ch][write_pos[ch]] = smp;
        return scaled[SAMPLE_BITS-1:0];
    endfunction

    always @(posedge clk)
    begin : monitor
        stereo_frame_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_REV_LEN_LEFT:     rev_len[LEFT_CH]     = cfg_data[LEN_W-1:0];
                    REG_REV_LEN_RIGHT:    rev_len[RIGHT_CH]    = cfg_data[LEN_W-1:0];
                    REG_FADE_LEN_LEFT:    fade_len[LEFT_CH]    = cfg_data[FADE_W-1:0];
                    REG_FADE_LEN_RIGHT:   fade_len[RIGHT_CH]   = cfg_data[FADE_W-1:0];
                    REG_FADE_RECIP_LEFT:  fade_recip[LEFT_CH]  = cfg_data[RECIP_W-1:0];
                    REG_FADE_RECIP_RIGHT: fade_recip[RIGHT_CH] = cfg_data[RECIP_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                want.left  = reverse_faded_sample(LEFT_CH, left_in);
                want.right = reverse_faded_sample(RIGHT_CH, right_in);
                expected_frames.insert(expected_frames.size(), want);
            end

            if (out_valid && !out_stall)
            begin
                if (expected_frames.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: unexpected output beat: expected none, got %0d / %0d",
                                 $time, left_out, right_out);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    frames_checked++;
                    if (left_out !== want.left)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: left_out mismatch: expected %0d, got %0d",
                                     $time, want.left, left_out);
                    end
                    if (right_out !== want.right)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: right_out mismatch: expected %0d, got %0d",
                                     $time, want.right, right_out);
                    end
                end
            end
            frames_pending = expected_frames.size();
        end
    end

endmodule

@@ verif/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: stimulus and verdict for the stereo reverse playback buffer
// Runs directed beats over the field extremes and the special length and
// fade settings, then randomized register settings with bursty input and a
// stalling receiver; the checker instance predicts and compares every beat.
// ---------------------------------------------------------------------------
module tb_top;
    import rpb_pkg::*;

    localparam int RANDOM_ITEMS   = 700;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 250;
    localparam int SETTLE_CYCLES  = 40;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_NEG1 = '1;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONE = SAMPLE_BITS'(1);

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int unsigned FULL_GAIN = 1 << Q_BITS;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          cfg_we;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_W-1:0]              cfg_data;

    int mismatch_count;
    int frames_pending;
    int frames_checked;
    int beats_accepted = 0;
    int idle_cycles    = 0;
    int settings_count = 0;

    reverse_playback_buffer_with_fades_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rpb_frame_checker frame_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .left_in        (left_in),
        .right_in       (right_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .left_out       (left_out),
        .right_out      (right_out),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .frames_pending (frames_pending),
        .frames_checked (frames_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The idle limit covers the store clearing sweep that follows reset.
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            beats_accepted <= beats_accepted + 1;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d frames outstanding",
                     $time, frames_pending);
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: switches at random between stall modes and holds off for a
    // long stretch once, so the block backs up into its input.
    initial
    begin : receiver
        stall_mode_t mode;
        int          mode_left;
        bit          hold_done;
        out_stall = 1'b0;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && beats_accepted >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(5, 80);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
                    default:     out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] boundary_sample(int k);
        case (k % 6)
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_NEG1;
            3:       return SAMPLE_ONE;
            4:       return '0;
            default: return SAMPLE_MAX - SAMPLE_BITS'(1);
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_NEG1;
            3:       return '0;
            4:       return SAMPLE_BITS'(signed'(raw[7:0]));
            default: return raw[SAMPLE_BITS-1:0];
        endcase
    endfunction

    // Offers one beat from a falling edge and returns on the falling edge
    // after it was taken; the payload holds while the block stalls.
    task automatic send_frame(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
        in_valid <= 1'b1;
        left_in  <= l;
        right_in <= r;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic run_items(input int count);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 20);
        for (int i = 0; i < count; i++)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
                repeat (gap) @(negedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 12);
            end
            send_frame(random_sample(), random_sample());
            burst_left--;
        end
        in_valid <= 1'b0;
    endtask

    // Waits on falling edges until every predicted frame has come out.
    task automatic drain();
        while (frames_pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_settings(input int unsigned len_l, input int unsigned len_r,
                                  input int unsigned fade_l, input int unsigned fade_r,
                                  input int unsigned recip_l, input int unsigned recip_r,
                                  input bit spare_write);
        int unsigned          vals [6];
        logic [CFG_IDX_W-1:0] idx [6];
        vals = '{len_l, len_r, fade_l, fade_r, recip_l, recip_r};
        idx  = '{REG_REV_LEN_LEFT, REG_REV_LEN_RIGHT, REG_FADE_LEN_LEFT,
                 REG_FADE_LEN_RIGHT, REG_FADE_RECIP_LEFT, REG_FADE_RECIP_RIGHT};
        for (int k = 0; k < 6; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= CFG_W'(vals[k]);
            @(negedge clk);
        end
        if (spare_write)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= ($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI;
            cfg_data  <= CFG_W'($urandom());
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    function automatic int unsigned pick_length();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return 1;
            2:       return MAX_REV_LEN;
            3:       return $urandom_range(MAX_REV_LEN + 1, (1 << LEN_W) - 1);
            4:       return $urandom_range(65, 4096);
            default: return $urandom_range(2, 48);
        endcase
    endfunction

    function automatic int unsigned pick_fade(int unsigned len);
        int unsigned top;
        top = (len > 96) ? 32 : len / 2 + 1;
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(0, (1 << FADE_W) - 1);
            2:       return 8192;
            default: return $urandom_range(1, top);
        endcase
    endfunction

    function automatic int unsigned pick_recip(int unsigned fade);
        if (fade == 0 || $urandom_range(0, 5) == 0)
        begin
            case ($urandom_range(0, 2))
                0:       return 8;
                1:       return FULL_GAIN;
                default: return $urandom_range(0, (1 << RECIP_W) - 1);
            endcase
        end
        return FULL_GAIN / fade;
    endfunction

    initial
    begin : stimulus
        int unsigned len_l, len_r, fade_l, fade_r;
        int          items_sent;
        int          phase_items;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        left_in   = '0;
        right_in  = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_REV_LEN_LEFT;
        cfg_data  = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings give length one, so every sample passes through.
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_frame('0, SAMPLE_NEG1);
        send_frame(SAMPLE_NEG1, SAMPLE_ONE);
        send_frame(SAMPLE_ONE, '0);
        in_valid <= 1'b0;
        drain();

        // Short stores with a half-scale ramp on the left, no fade on the right.
        write_settings(8, 5, 2, 0, FULL_GAIN / 2, FULL_GAIN, 1'b1);
        for (int k = 0; k < 12; k++)
            send_frame(boundary_sample(k), boundary_sample(k + 3));
        in_valid <= 1'b0;
        drain();

        // Zero length on the left, an oversized length on the right.
        write_settings(0, (1 << LEN_W) - 1, 1, 8192, FULL_GAIN, 8, 1'b1);
        for (int k = 0; k < 4; k++)
            send_frame(boundary_sample(k + 1), boundary_sample(k));
        in_valid <= 1'b0;
        drain();

        // The right write position now lies beyond the shortened length.
        write_settings(3, 2, 1, 1, FULL_GAIN, (1 << RECIP_W) - 1, 1'b0);
        for (int k = 0; k < 4; k++)
            send_frame(boundary_sample(k + 2), boundary_sample(k + 5));
        in_valid <= 1'b0;
        drain();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            len_l  = pick_length();
            len_r  = pick_length();
            fade_l = pick_fade(len_l);
            fade_r = pick_fade(len_r);
            write_settings(len_l, len_r, fade_l, fade_r, pick_recip(fade_l),
                           pick_recip(fade_r), ($urandom_range(0, 3) == 0));
            phase_items = $urandom_range(20, 80);
            run_items(phase_items);
            items_sent += phase_items;
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Run covered %0d input beats under %0d register settings.",
                 beats_accepted, settings_count);
        $display("%0d output frames compared, %0d mismatches, %0d frames outstanding.",
                 frames_checked, mismatch_count, frames_pending);
        if (mismatch_count == 0 && frames_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
